/* hw/rtl/crc32c_pkg.sv */
// Shared constants, types and GF(2) matrix helpers for the CRC-32C stream unit.
package crc32c_pkg;

	localparam int BYTES_PER_ITEM = 8;
	localparam int DATA_W         = 64;
	localparam int CRC_W          = 32;
	localparam int CNT_W          = 4;
	localparam int SHIFT_W        = $clog2(BYTES_PER_ITEM + 1);

	// Reflected Castagnoli polynomial
	localparam logic [CRC_W-1:0] POLY = 32'h82F63B78;

	// Column i holds the image of bit i
	typedef logic [CRC_W-1:0][CRC_W-1:0] crc_mat_t;
	// Entry n advances a CRC by n zero bytes
	typedef crc_mat_t [BYTES_PER_ITEM:0] crc_tab_t;
	typedef logic [BYTES_PER_ITEM-1:0][CRC_W-1:0] lane_vec_t;

	// Control carried alongside the lane results
	typedef struct packed {
		logic               start_req;
		logic [CRC_W-1:0]   seed;
		logic [SHIFT_W-1:0] n;
		logic               last;
	} beat_ctl_t;

	// Elaboration-time build of the zero-byte advance matrices
	function automatic crc_tab_t gen_tab();
		crc_tab_t         tab;
		logic [CRC_W-1:0] c;
		for (int n = 0; n <= BYTES_PER_ITEM; n++) begin
			for (int i = 0; i < CRC_W; i++) begin
				c = CRC_W'(1) << i;
				for (int s = 0; s < 8 * n; s++) begin
					c = c[0] ? ((c >> 1) ^ POLY) : (c >> 1);
				end
				tab[n][i] = c;
			end
		end
		return tab;
	endfunction

	localparam crc_tab_t ADV_TAB = gen_tab();

	// Matrix times vector over GF(2): XOR of the selected columns
	function automatic logic [CRC_W-1:0] mat_apply(crc_mat_t m, logic [CRC_W-1:0] v);
		logic [CRC_W-1:0] r;
		r = '0;
		for (int i = 0; i < CRC_W; i++) begin
			if (v[i]) begin
				r = r ^ m[i];
			end
		end
		return r;
	endfunction

endpackage

/* hw/rtl/crc32c_lane.sv */
// One byte lane: the byte's contribution advanced to the end of the beat.
module crc32c_lane (
	input  logic [7:0]                      byte_in,
	input  logic [crc32c_pkg::SHIFT_W-1:0]  shift,
	input  logic                            en,
	output logic [crc32c_pkg::CRC_W-1:0]    contrib
);
	import crc32c_pkg::*;

	crc_mat_t mat;

	// Pick the advance matrix for this byte and the bytes that follow it
	always_comb begin
		if (shift > SHIFT_W'(BYTES_PER_ITEM)) begin
			mat = '0;
		end else begin
			mat = ADV_TAB[shift];
		end
	end

	// Unused lanes add nothing
	assign contrib = en ? mat_apply(mat, {{(CRC_W-8){1'b0}}, byte_in}) : '0;

endmodule

/* hw/rtl/crc32c_merge.sv */
// Merge stage: folds lane results into the running CRC and holds the result beat.
module crc32c_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  crc32c_pkg::beat_ctl_t         ctl_s1,
	input  crc32c_pkg::lane_vec_t         contrib_s1,
	output logic                          adv,
	output logic [crc32c_pkg::CRC_W-1:0]  crc_value,
	output logic                          done_res,
	output logic                          out_valid,
	input  logic                          out_ready
);
	import crc32c_pkg::*;

	logic [CRC_W-1:0] running_q;
	logic [CRC_W-1:0] crc_q;
	logic             done_q;
	logic             out_valid_q;
	logic [CRC_W-1:0] base;
	logic [CRC_W-1:0] lane_sum;
	logic [CRC_W-1:0] crc_nxt;

	// Stage 1 beat moves on when the output register is free or being emptied
	assign adv = valid_s1 && (!out_valid_q || out_ready);

	// XOR of all lane contributions
	always_comb begin
		lane_sum = '0;
		for (int k = 0; k < BYTES_PER_ITEM; k++) begin
			lane_sum = lane_sum ^ contrib_s1[k];
		end
	end

	// Seed or running value, advanced past this beat's bytes
	assign base    = ctl_s1.start_req ? ctl_s1.seed : running_q;
	assign crc_nxt = mat_apply(ADV_TAB[ctl_s1.n], base) ^ lane_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= adv || (out_valid_q && !out_ready);
			if (adv) begin
				running_q <= crc_nxt;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			crc_q  <= crc_nxt;
			done_q <= ctl_s1.last;
		end
	end

	assign crc_value = crc_q;
	assign done_res  = done_q;
	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_running_matches_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (running_q == crc_q))
		else $error("running CRC differs from the held result");
	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && !valid_s1) |=> !out_valid_q)
		else $error("output beat not released after being taken");
	a_running_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(running_q))
		else $error("running CRC changed without a beat");
`endif

endmodule

/* hw/rtl/crc32c_stream_update_unit.sv */
// Top level of the raw CRC-32C stream update unit.
//
// Raw CRC-32C (reflected polynomial 0x82F63B78, no inversion) over a stream of
// beats of up to eight bytes, byte 0 in bits 7:0 first. Each beat gives one
// result: the running CRC after its bytes and an echo of last. start_req loads
// seed before the beat's bytes; a byte_count above eight counts as eight, and
// a count of zero passes the current value through. The unit accepts one beat
// per cycle while its results are taken. A beat passes the stage 1 register
// and then the output register before its result is presented. Stage 1 runs
// eight byte lanes side by side, and the merge stage closes the running-CRC
// loop through one 32-by-32 XOR matrix chosen by the byte count, so that loop
// sets the one-cycle rate. Results wait in the output register; while one
// waits, stage 1 can still take one new beat before in_ready drops.
module crc32c_stream_update_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            start_req,
	input  logic [crc32c_pkg::CRC_W-1:0]    seed,
	input  logic [crc32c_pkg::DATA_W-1:0]   data_word,
	input  logic [crc32c_pkg::CNT_W-1:0]    byte_count,
	input  logic                            last,
	output logic [crc32c_pkg::CRC_W-1:0]    crc_value,
	output logic                            done_res,
	output logic                            out_valid,
	input  logic                            out_ready
);
	import crc32c_pkg::*;

	logic               valid_s1;
	beat_ctl_t          ctl_s1;
	lane_vec_t          contrib_s1;
	lane_vec_t          contrib;
	logic [SHIFT_W-1:0] n;
	logic               adv;
	logic               accept;

	// Count saturates at the beat width
	assign n = (byte_count > CNT_W'(BYTES_PER_ITEM)) ? SHIFT_W'(BYTES_PER_ITEM)
		: byte_count[SHIFT_W-1:0];

	// Byte lanes
	for (genvar k = 0; k < BYTES_PER_ITEM; k++) begin : g_lane
		crc32c_lane u_lane (
			.byte_in (data_word[8*k +: 8]),
			.shift   (n - SHIFT_W'(k)),
			.en      (n > SHIFT_W'(k)),
			.contrib (contrib[k])
		);
	end

	assign in_ready = !valid_s1 || adv;
	assign accept   = in_valid && in_ready;

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv);
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.start_req <= start_req;
			ctl_s1.seed      <= seed;
			ctl_s1.n         <= n;
			ctl_s1.last      <= last;
			contrib_s1       <= contrib;
		end
	end

	crc32c_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.ctl_s1     (ctl_s1),
		.contrib_s1 (contrib_s1),
		.adv        (adv),
		.crc_value  (crc_value),
		.done_res   (done_res),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule

/* tb/crc32c_stream_update_checker.sv */
// Scoreboard for the CRC-32C stream unit: watches both channels, predicts each result and compares.
module crc32c_stream_update_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          start_req,
	input  logic [crc32c_pkg::CRC_W-1:0]  seed,
	input  logic [crc32c_pkg::DATA_W-1:0] data_word,
	input  logic [crc32c_pkg::CNT_W-1:0]  byte_count,
	input  logic                          last,
	input  logic [crc32c_pkg::CRC_W-1:0]  crc_value,
	input  logic                          done_res,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          end_of_run,
	output int                            fail_count,
	output int                            pending_count,
	output int                            accepted_count,
	output int                            checked_count
);
	import crc32c_pkg::*;

	// Castagnoli polynomial, bit-reversed form
	localparam logic [CRC_W-1:0] CASTAGNOLI_REFLECTED = 32'h82F63B78;

	typedef struct packed {
		logic [CRC_W-1:0] crc;
		logic             done;
	} crc_result_t;

	crc_result_t      expected_crc_q[$];
	crc_result_t      oldest;
	logic [CRC_W-1:0] running_crc = '0;
	logic             leftovers_checked = 1'b0;
	int               mismatches = 0;
	int               beats_in = 0;
	int               results_seen = 0;

	// One byte through the bitwise LFSR, LSB first
	function automatic logic [CRC_W-1:0] crc32c_shift_byte(logic [CRC_W-1:0] crc,
		logic [7:0] octet);
		logic [CRC_W-1:0] c;
		c = crc ^ {24'h0, octet};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CASTAGNOLI_REFLECTED) : (c >> 1);
		end
		return c;
	endfunction

	// Whole beat: counts past capacity saturate, a count of zero passes through
	function automatic logic [CRC_W-1:0] crc32c_fold_beat(logic [CRC_W-1:0] crc,
		logic [DATA_W-1:0] data, logic [CNT_W-1:0] cnt);
		int               n;
		logic [CRC_W-1:0] c;
		n = (int'(cnt) > BYTES_PER_ITEM) ? BYTES_PER_ITEM : int'(cnt);
		c = crc;
		for (int k = 0; k < n; k++) begin
			c = crc32c_shift_byte(c, data[8*k +: 8]);
		end
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			running_crc = '0;
			expected_crc_q.delete();
			fail_count     <= 0;
			pending_count  <= 0;
			accepted_count <= 0;
			checked_count  <= 0;
		end else begin
			// result beat against the oldest prediction
			if (out_valid && out_ready) begin
				if (expected_crc_q.size() == 0) begin
					report_mismatch($sformatf("result crc %h done %b with nothing expected",
						crc_value, done_res));
				end else begin
					oldest = expected_crc_q.pop_front();
					if (crc_value !== oldest.crc)
						report_mismatch($sformatf("crc_value got %h want %h",
							crc_value, oldest.crc));
					if (done_res !== oldest.done)
						report_mismatch($sformatf("done_res got %b want %b",
							done_res, oldest.done));
					results_seen++;
				end
			end
			// input beat: start loads the seed, then the bytes are absorbed
			if (in_valid && in_ready) begin
				running_crc = crc32c_fold_beat(start_req ? seed : running_crc,
					data_word, byte_count);
				expected_crc_q.push_back('{crc: running_crc, done: last});
				beats_in++;
			end
			// anything still owed once the run has drained
			if (end_of_run && !leftovers_checked) begin
				leftovers_checked = 1'b1;
				if (expected_crc_q.size() != 0)
					report_mismatch($sformatf("%0d results never arrived",
						expected_crc_q.size()));
			end
			fail_count     <= mismatches;
			pending_count  <= expected_crc_q.size();
			accepted_count <= beats_in;
			checked_count  <= results_seen;
		end
	end

endmodule

/* tb/crc32c_stream_update_unit_tb.sv */
// Top of the CRC-32C stream unit testbench: clock, reset, beat stimulus, back-pressure, verdict.
module crc32c_stream_update_unit_tb;
	import crc32c_pkg::*;

	localparam int RANDOM_BEATS = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic              start;
		logic [CRC_W-1:0]  seed;
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  cnt;
		logic              last;
	} crc_beat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              start_req = 1'b0;
	logic [CRC_W-1:0]  seed = '0;
	logic [DATA_W-1:0] data_word = '0;
	logic [CNT_W-1:0]  byte_count = '0;
	logic              last = 1'b0;
	logic [CRC_W-1:0]  crc_value;
	logic              done_res;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              end_of_run = 1'b0;

	int fail_count;
	int pending_count;
	int accepted_count;
	int checked_count;

	crc_beat_t stim_q[$];
	int        directed_beats = 0;
	int        message_beats = 0;
	int        message_total = 0;
	int        loose_beats = 0;
	int        odd_counts = 0;

	always #4 clk = ~clk;

	crc32c_stream_update_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_req  (start_req),
		.seed       (seed),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last       (last),
		.crc_value  (crc_value),
		.done_res   (done_res),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

	crc32c_stream_update_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.start_req      (start_req),
		.seed           (seed),
		.data_word      (data_word),
		.byte_count     (byte_count),
		.last           (last),
		.crc_value      (crc_value),
		.done_res       (done_res),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.end_of_run     (end_of_run),
		.fail_count     (fail_count),
		.pending_count  (pending_count),
		.accepted_count (accepted_count),
		.checked_count  (checked_count)
	);

	task automatic add_beat(input logic start, input logic [CRC_W-1:0] sd,
		input logic [DATA_W-1:0] data, input logic [CNT_W-1:0] cnt, input logic lst);
		stim_q.push_back('{start: start, seed: sd, data: data, cnt: cnt, last: lst});
		if (cnt == 0 || int'(cnt) > BYTES_PER_ITEM)
			odd_counts++;
	endtask

	// mostly in range, now and then zero or past capacity
	function automatic logic [CNT_W-1:0] pick_count();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return CNT_W'($urandom_range(BYTES_PER_ITEM + 1, 15));
		return CNT_W'($urandom_range(1, BYTES_PER_ITEM));
	endfunction

	function automatic logic [CRC_W-1:0] pick_seed();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return CRC_W'($urandom);
	endfunction

	function automatic logic [DATA_W-1:0] pick_data();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// Sender: bursts of beats with random gaps; valid holds until taken
	int gap_left = 0;
	int burst_left = 1;
	int beats_presented = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || beats_presented == stim_q.size()) begin
					in_valid <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end else begin
					in_valid   <= 1'b1;
					start_req  <= stim_q[beats_presented].start;
					seed       <= stim_q[beats_presented].seed;
					data_word  <= stim_q[beats_presented].data;
					byte_count <= stim_q[beats_presented].cnt;
					last       <= stim_q[beats_presented].last;
					beats_presented++;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 32);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// Receiver: rotating ready pattern, re-chosen each time pattern_age wraps
	logic [7:0] ready_pattern = 8'hFF;
	int         pattern_age = 0;

	always @(posedge clk) begin
		if (pattern_age == 63) begin
			pattern_age = 0;
			case ($urandom_range(0, 3))
				0: ready_pattern = 8'hFF;
				1: ready_pattern = 8'h01;
				default: ready_pattern = 8'($urandom) | 8'h01;
			endcase
		end else begin
			pattern_age++;
		end
		out_ready <= ready_pattern[0];
		ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
	end

	// Watchdog
	int cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int msg_len;
		logic [CRC_W-1:0] msg_seed;

		// directed: zero data from zero seed, then all ones, then continue after last
		add_beat(1'b1, '0, '0, CNT_W'(8), 1'b0);
		add_beat(1'b0, CRC_W'($urandom), '1, CNT_W'(8), 1'b1);
		add_beat(1'b0, '0, 64'h0123_4567_89AB_CDEF, CNT_W'(4), 1'b1);
		add_beat(1'b1, '1, '1, CNT_W'(8), 1'b0);
		// zero byte count, with and without a seed load
		add_beat(1'b0, CRC_W'($urandom), pick_data(), '0, 1'b0);
		add_beat(1'b1, 32'hA5A5_5A5A, pick_data(), '0, 1'b1);
		// start a message that the next start cuts off before any last beat
		add_beat(1'b1, 32'h1234_5678, {$urandom, $urandom}, CNT_W'(3), 1'b0);
		// every count past capacity
		for (int c = BYTES_PER_ITEM + 1; c <= 15; c++)
			add_beat(c == BYTES_PER_ITEM + 1, CRC_W'($urandom), {$urandom, $urandom},
				CNT_W'(c), c == 15);
		// each short count with unused upper bytes set
		for (int c = 1; c < BYTES_PER_ITEM; c++)
			add_beat(c == 1, '1, '1, CNT_W'(c), c == BYTES_PER_ITEM - 1);
		add_beat(1'b1, '1, '0, CNT_W'(15), 1'b1);
		directed_beats = stim_q.size();

		// random: mostly whole messages, some loose beats
		while (stim_q.size() - directed_beats < RANDOM_BEATS) begin
			if ($urandom_range(0, 99) < 85) begin
				msg_len = $urandom_range(1, 8);
				msg_seed = pick_seed();
				for (int i = 0; i < msg_len; i++)
					add_beat(i == 0, (i == 0) ? msg_seed : CRC_W'($urandom), pick_data(),
						pick_count(), i == msg_len - 1);
				message_beats += msg_len;
				message_total++;
			end else begin
				add_beat(1'($urandom_range(0, 1)), pick_seed(), pick_data(), pick_count(),
					1'($urandom_range(0, 1)));
				loose_beats++;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < stim_q.size())
			@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		end_of_run <= 1'b1;
		repeat (2) @(posedge clk);

		$display("Sent %0d beats: %0d directed, %0d in %0d random messages, %0d loose",
			stim_q.size(), directed_beats, message_beats, message_total, loose_beats);
		$display("%0d results compared; %0d beats had a zero or oversized byte count",
			checked_count, odd_counts);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/crc32c_pkg.sv
hw/rtl/crc32c_lane.sv
hw/rtl/crc32c_merge.sv
hw/rtl/crc32c_stream_update_unit.sv
tb/crc32c_stream_update_checker.sv
tb/crc32c_stream_update_unit_tb.sv
